// ===== hw/rtl/eno_quadratic_interpolant_macros.svh =====
// ----------------------------------------------------------------------------
// ENO quadratic interpolant assertion macros
// Concurrent checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ENO_QUADRATIC_INTERPOLANT_MACROS_SVH
`define ENO_QUADRATIC_INTERPOLANT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define EQI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eqi implication check failed");

// antecedent implies consequent a fixed number of cycles later
`define EQI_ASSERT_AFTER(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("eqi latency check failed");

`endif

// ===== hw/rtl/eqi_pkg.sv =====
// ----------------------------------------------------------------------------
// eqi_pkg
// Widths and fixed-point scaling for the ENO quadratic interpolant.
// ----------------------------------------------------------------------------
package eqi_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int POS_INT_BITS  = 12;
  localparam int POS_FRAC_BITS = 8;
  localparam int POS_BITS      = POS_INT_BITS + POS_FRAC_BITS;

  // result field widths
  localparam int QUAD_W  = 18;
  localparam int LIN_W   = 42;
  localparam int CONST_W = 60;
  localparam int SLOPE_W = 43;

  // internal widths
  localparam int D2_W   = SAMPLE_BITS + 2;            // second differences
  localparam int DIFF_W = SAMPLE_BITS + 1;            // first difference
  localparam int PROD_W = D2_W + POS_BITS + 1;        // q * x
  localparam int RX_W   = DIFF_W + POS_BITS + 1;      // x * diff
  localparam int M_W    = PROD_W + POS_BITS + 1;      // q * x * x
  localparam int LINX_W = (LIN_W > SLOPE_W) ? LIN_W : SLOPE_W;

  // pipeline depth, start to done
  localparam int LATENCY = 5;

endpackage

// ===== hw/rtl/eno_quadratic_interpolant.sv =====
// ----------------------------------------------------------------------------
// eno_quadratic_interpolant
// Second-order ENO interpolant: stencil choice, quadratic coefficients and
// end slopes of one interval, five-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  input    | start / busy     | sample_prev/here/next/far, start_pos, end_pos
//  result   | done (strobe)    | dir_forward, coef_quad, coef_lin, coef_const,
//           |                  | slope_start, slope_end
//
//  One transaction enters per clock; busy is always low.
//  Result strobes on done as stage 5 loads the output registers, one per transaction,
//  in order; depth is set by the two chained multiplies (q*x, then q*x*x).
//  rst (synchronous) clears the stage valid bits; data registers are not reset.
//  The receiver cannot stall, so the pipeline never holds.
//
//  Stages:
//   1  second differences and first difference
//   2  magnitude compare, stencil select (backward on tie)
//   3  q*xs, q*xe, xs*diff
//   4  q*xs*xs, linear coefficient
//   5  constant coefficient, slopes -> output registers
// ----------------------------------------------------------------------------
`include "eno_quadratic_interpolant_macros.svh"

module eno_quadratic_interpolant (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [eqi_pkg::SAMPLE_BITS-1:0] sample_prev,
  input  logic signed [eqi_pkg::SAMPLE_BITS-1:0] sample_here,
  input  logic signed [eqi_pkg::SAMPLE_BITS-1:0] sample_next,
  input  logic signed [eqi_pkg::SAMPLE_BITS-1:0] sample_far,
  input  logic        [eqi_pkg::POS_BITS-1:0]    start_pos,
  input  logic        [eqi_pkg::POS_BITS-1:0]    end_pos,
  output logic                                  done,
  output logic                                  dir_forward,
  output logic signed [eqi_pkg::QUAD_W-1:0]      coef_quad,
  output logic signed [eqi_pkg::LIN_W-1:0]       coef_lin,
  output logic signed [eqi_pkg::CONST_W-1:0]     coef_const,
  output logic signed [eqi_pkg::SLOPE_W-1:0]     slope_start,
  output logic signed [eqi_pkg::SLOPE_W-1:0]     slope_end
);
  import eqi_pkg::*;

  function automatic logic [D2_W-1:0] mag(input logic signed [D2_W-1:0] v);
    mag = v[D2_W-1] ? D2_W'(-v) : D2_W'(v);
  endfunction

  // stage valid bits
  logic v1, v2, v3, v4;

  // ---------------- stage 1 ----------------
  logic signed [D2_W-1:0]        s1_fwd, s1_bwd;
  logic signed [DIFF_W-1:0]      s1_diff;
  logic signed [SAMPLE_BITS-1:0] s1_here;
  logic        [POS_BITS-1:0]    s1_xs, s1_xe;

  // ---------------- stage 2 ----------------
  logic signed [D2_W-1:0]        s2_cq;
  logic                          s2_fw;
  logic signed [DIFF_W-1:0]      s2_diff;
  logic signed [SAMPLE_BITS-1:0] s2_here;
  logic        [POS_BITS-1:0]    s2_xs, s2_xe;

  // ---------------- stage 3 ----------------
  logic signed [PROD_W-1:0]      s3_qxs, s3_qxe;
  logic signed [RX_W-1:0]        s3_rx;
  logic signed [D2_W-1:0]        s3_cq;
  logic                          s3_fw;
  logic signed [DIFF_W-1:0]      s3_diff;
  logic signed [SAMPLE_BITS-1:0] s3_here;
  logic        [POS_BITS-1:0]    s3_xs;

  // ---------------- stage 4 ----------------
  logic signed [M_W-1:0]         s4_m;
  logic signed [LINX_W-1:0]      s4_lin;
  logic signed [PROD_W-1:0]      s4_qxs, s4_qxe;
  logic signed [RX_W-1:0]        s4_rx;
  logic signed [D2_W-1:0]        s4_cq;
  logic                          s4_fw;
  logic signed [SAMPLE_BITS-1:0] s4_here;

  // stage 1 combinational: twice the half second differences
  logic signed [D2_W-1:0]   fwd_next, bwd_next;
  logic signed [DIFF_W-1:0] diff_next;

  always_comb begin
    fwd_next  = D2_W'(sample_far) - (D2_W'(sample_next) <<< 1) + D2_W'(sample_here);
    bwd_next  = D2_W'(sample_next) - (D2_W'(sample_here) <<< 1) + D2_W'(sample_prev);
    diff_next = DIFF_W'(sample_next) - DIFF_W'(sample_here);
  end

  // stage 2 combinational: strictly smaller forward wins, tie goes backward
  logic fw_next;
  assign fw_next = mag(s1_fwd) < mag(s1_bwd);

  // stage 5 combinational
  logic signed [CONST_W-1:0] cst_next;
  logic signed [SLOPE_W-1:0] s0_next, s1_next;

  always_comb begin
    cst_next = (CONST_W'(s4_here) <<< (2 * POS_FRAC_BITS + 1))
             + CONST_W'(s4_m)
             + (CONST_W'(s4_qxs) <<< POS_FRAC_BITS)
             - (CONST_W'(s4_rx) <<< (POS_FRAC_BITS + 1));
    s0_next  = (SLOPE_W'(s4_qxs) <<< 1) + SLOPE_W'(s4_lin);
    s1_next  = (SLOPE_W'(s4_qxe) <<< 1) + SLOPE_W'(s4_lin);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // stage 1
    s1_fwd  <= fwd_next;
    s1_bwd  <= bwd_next;
    s1_diff <= diff_next;
    s1_here <= sample_here;
    s1_xs   <= start_pos;
    s1_xe   <= end_pos;
    // stage 2
    s2_cq   <= fw_next ? s1_fwd : s1_bwd;
    s2_fw   <= fw_next;
    s2_diff <= s1_diff;
    s2_here <= s1_here;
    s2_xs   <= s1_xs;
    s2_xe   <= s1_xe;
    // stage 3: first products
    s3_qxs  <= PROD_W'(s2_cq) * PROD_W'($signed({1'b0, s2_xs}));
    s3_qxe  <= PROD_W'(s2_cq) * PROD_W'($signed({1'b0, s2_xe}));
    s3_rx   <= RX_W'(s2_diff) * RX_W'($signed({1'b0, s2_xs}));
    s3_cq   <= s2_cq;
    s3_fw   <= s2_fw;
    s3_diff <= s2_diff;
    s3_here <= s2_here;
    s3_xs   <= s2_xs;
    // stage 4: q*x*x, l = 2*one*diff - 2*q*x - one*q
    s4_m    <= M_W'(s3_qxs) * M_W'($signed({1'b0, s3_xs}));
    s4_lin  <= (LINX_W'(s3_diff) <<< (POS_FRAC_BITS + 1))
             - (LINX_W'(s3_qxs) <<< 1)
             - (LINX_W'(s3_cq) <<< POS_FRAC_BITS);
    s4_qxs  <= s3_qxs;
    s4_qxe  <= s3_qxe;
    s4_rx   <= s3_rx;
    s4_cq   <= s3_cq;
    s4_fw   <= s3_fw;
    s4_here <= s3_here;
    // stage 5: output registers
    dir_forward <= s4_fw;
    coef_quad   <= QUAD_W'(s4_cq);
    coef_lin    <= LIN_W'(s4_lin);
    coef_const  <= cst_next;
    slope_start <= s0_next;
    slope_end   <= s1_next;
  end

  // no back-pressure anywhere, a transaction is taken every cycle
  assign busy = 1'b0;

  // every accepted transaction strobes out after the pipeline depth
  `EQI_ASSERT_AFTER(a_latency, start && !busy, LATENCY, done)
  // and no strobe without a transaction that far back
  `EQI_ASSERT_IMPL(a_no_phantom, done, $past(start && !busy, LATENCY))
  // slope at start is lin plus an even term, so the low bits agree
  `EQI_ASSERT_IMPL(a_slope_lsb, done, slope_start[0] == coef_lin[0])

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// ENO quadratic interpolant testbench
// Drives four-sample windows and interval positions through the start/busy
// command port, predicts stencil choice, coefficients and end slopes for
// every accepted transaction, and checks each done strobe against the oldest
// prediction in order. Directed corner windows come first, then random ones
// with random idle gaps.
// ----------------------------------------------------------------------------
module testbench;

  import eqi_pkg::*;

  localparam int RANDOM_WINDOWS = 1450;
  localparam int STALL_LIMIT    = 2000;  // cycles with no transaction at all
  localparam int LONG_GAP_MAX   = 60;

  // one input transaction, fields in port order
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_prev;
    logic signed [SAMPLE_BITS-1:0] sample_here;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic signed [SAMPLE_BITS-1:0] sample_far;
    logic        [POS_BITS-1:0]    start_pos;
    logic        [POS_BITS-1:0]    end_pos;
  } window_t;

  // one result transaction
  typedef struct packed {
    logic                        dir_forward;
    logic signed [QUAD_W-1:0]    coef_quad;
    logic signed [LIN_W-1:0]     coef_lin;
    logic signed [CONST_W-1:0]   coef_const;
    logic signed [SLOPE_W-1:0]   slope_start;
    logic signed [SLOPE_W-1:0]   slope_end;
  } interp_t;

  typedef logic signed [63:0] wide_t;

  // --------------------------------------------------------------------------
  // Scoreboard: turns each accepted window into its expected interpolant and
  // matches done strobes against them in arrival order.
  // --------------------------------------------------------------------------
  class interp_scoreboard;
    interp_t expected_q[$];
    int      failures;

    function new();
      failures = 0;
    endfunction

    // Exact fixed point, 64-bit wrap; every value fits at these widths.
    function automatic interp_t interpolate(window_t w);
      wide_t   p0, p1, p2, p3, xs, xe, one;
      wide_t   fwd, bwd, mag_f, mag_b, cq, diff, lin, cst, s0, s1;
      interp_t r;
      p0  = wide_t'(w.sample_prev);
      p1  = wide_t'(w.sample_here);
      p2  = wide_t'(w.sample_next);
      p3  = wide_t'(w.sample_far);
      xs  = wide_t'(w.start_pos);
      xe  = wide_t'(w.end_pos);
      one = wide_t'(1) <<< POS_FRAC_BITS;
      // twice the half second differences
      fwd   = p3 - 2 * p2 + p1;
      bwd   = p2 - 2 * p1 + p0;
      mag_f = (fwd < 0) ? -fwd : fwd;
      mag_b = (bwd < 0) ? -bwd : bwd;
      r.dir_forward = (mag_f < mag_b);  // tie keeps backward
      cq   = r.dir_forward ? fwd : bwd;
      diff = p2 - p1;
      lin  = diff * (2 * one) - cq * (2 * xs + one);
      cst  = p1 * (2 * one * one) + cq * xs * (xs + one) - xs * diff * (2 * one);
      s0   = 2 * cq * xs + lin;
      s1   = 2 * cq * xe + lin;
      r.coef_quad   = cq[QUAD_W-1:0];
      r.coef_lin    = lin[LIN_W-1:0];
      r.coef_const  = cst[CONST_W-1:0];
      r.slope_start = s0[SLOPE_W-1:0];
      r.slope_end   = s1[SLOPE_W-1:0];
      return r;
    endfunction

    function void note_window(window_t w);
      expected_q.push_back(interpolate(w));
    endfunction

    function automatic bit field_ok(string name, wide_t exp_v, wide_t act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        return 0;
      end
      return 1;
    endfunction

    function void check_result(interp_t act);
      interp_t exp_r;
      bit      ok;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, act);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      ok = 1;
      ok &= field_ok("dir_forward", wide_t'(exp_r.dir_forward), wide_t'(act.dir_forward));
      ok &= field_ok("coef_quad",   wide_t'(exp_r.coef_quad),   wide_t'(act.coef_quad));
      ok &= field_ok("coef_lin",    wide_t'(exp_r.coef_lin),    wide_t'(act.coef_lin));
      ok &= field_ok("coef_const",  wide_t'(exp_r.coef_const),  wide_t'(act.coef_const));
      ok &= field_ok("slope_start", wide_t'(exp_r.slope_start), wide_t'(act.slope_start));
      ok &= field_ok("slope_end",   wide_t'(exp_r.slope_end),   wide_t'(act.slope_end));
      if (!ok) failures++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic clk, rst, start, busy, done;
  logic signed [SAMPLE_BITS-1:0] sample_prev, sample_here, sample_next, sample_far;
  logic        [POS_BITS-1:0]    start_pos, end_pos;
  logic                          dir_forward;
  logic signed [QUAD_W-1:0]      coef_quad;
  logic signed [LIN_W-1:0]       coef_lin;
  logic signed [CONST_W-1:0]     coef_const;
  logic signed [SLOPE_W-1:0]     slope_start, slope_end;

  interp_scoreboard sb;

  eno_quadratic_interpolant dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample_prev (sample_prev),
    .sample_here (sample_here),
    .sample_next (sample_next),
    .sample_far  (sample_far),
    .start_pos   (start_pos),
    .end_pos     (end_pos),
    .done        (done),
    .dir_forward (dir_forward),
    .coef_quad   (coef_quad),
    .coef_lin    (coef_lin),
    .coef_const  (coef_const),
    .slope_start (slope_start),
    .slope_end   (slope_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor. Inputs change on the falling edge and the DUT updates its
  // registers with nonblocking writes, so a read here at the rising edge
  // sees the values that the edge itself samples.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.note_window({sample_prev, sample_here, sample_next, sample_far,
                        start_pos, end_pos});
      if (done)
        sb.check_result({dir_forward, coef_quad, coef_lin, coef_const,
                         slope_start, slope_end});
    end
  end

  // Watchdog: a hang shows up as a long run of edges where neither an input
  // transaction is taken nor a result strobed.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("** eno_quadratic_interpolant: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Idle first as idle_cycles asks (start low, payload junk), then present the
  // window and hold it until an edge with busy low takes it.
  task automatic send_window(input window_t w, input int unsigned idle_cycles);
    repeat (idle_cycles) begin
      @(negedge clk);
      start = 1'b0;
      {sample_prev, sample_here, sample_next, sample_far, start_pos, end_pos}
        = window_t'({$urandom, $urandom, $urandom, $urandom});
    end
    @(negedge clk);
    {sample_prev, sample_here, sample_next, sample_far, start_pos, end_pos} = w;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_directed(input int prev_s, input int here_s, input int next_s,
                               input int far_s, input int xs, input int xe);
    window_t w;
    w.sample_prev = prev_s[SAMPLE_BITS-1:0];
    w.sample_here = here_s[SAMPLE_BITS-1:0];
    w.sample_next = next_s[SAMPLE_BITS-1:0];
    w.sample_far  = far_s[SAMPLE_BITS-1:0];
    w.start_pos   = xs[POS_BITS-1:0];
    w.end_pos     = xe[POS_BITS-1:0];
    send_window(w, 0);
  endtask

  // Samples: full range, rails, or small values near zero.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2, 3:    return SAMPLE_BITS'($urandom_range(0, 16) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Positions: mostly anywhere, some near the origin, some at the ends.
  function automatic logic [POS_BITS-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return POS_BITS'($urandom_range(0, 4095));
      default: return POS_BITS'($urandom);
    endcase
  endfunction

  // Random window. About a quarter are built around a base level with equal
  // or opposite second differences, so the tie rule gets hit often.
  function automatic window_t pick_window();
    window_t w;
    int base, d1, d2, b;
    if ($urandom_range(0, 3) == 0) begin
      base = $urandom_range(0, 32000) - 16000;
      d1   = $urandom_range(0, 200) - 100;
      d2   = $urandom_range(0, 200) - 100;
      b    = $urandom_range(0, 200) - 100;
      w.sample_here = SAMPLE_BITS'(base + d1);
      w.sample_next = SAMPLE_BITS'(base + d2);
      w.sample_prev = SAMPLE_BITS'(2 * (base + d1) - (base + d2) + b);
      // far side: same difference, its negative, or one off
      case ($urandom_range(0, 2))
        0:       w.sample_far = SAMPLE_BITS'(2 * (base + d2) - (base + d1) + b);
        1:       w.sample_far = SAMPLE_BITS'(2 * (base + d2) - (base + d1) - b);
        default: w.sample_far = SAMPLE_BITS'(2 * (base + d2) - (base + d1) + b - 1);
      endcase
    end else begin
      w.sample_prev = pick_sample();
      w.sample_here = pick_sample();
      w.sample_next = pick_sample();
      w.sample_far  = pick_sample();
    end
    w.start_pos = pick_pos();
    w.end_pos   = pick_pos();
    return w;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(11, LONG_GAP_MAX);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit burst;
    sb = new();
    rst   = 1'b1;
    start = 1'b0;
    {sample_prev, sample_here, sample_next, sample_far, start_pos, end_pos} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners, back to back.
    send_directed(0, 0, 0, 0, 0, 0);                         // flat, origin
    send_directed(32767, 32767, 32767, 32767, 'hFFFFF, 'hFFFFF);
    send_directed(-32768, -32768, -32768, -32768, 'hFFFFF, 0);
    // largest opposite second differences: magnitudes tie, backward kept
    send_directed(-32768, 32767, -32768, 32767, 'hFFFFF, 0);
    send_directed(32767, -32768, 32767, -32768, 0, 'hFFFFF);
    send_directed(1, 0, 0, 1, 256, 512);                     // equal, tie
    send_directed(100, 0, 0, 1, 'h00100, 'h00200);           // forward smaller
    send_directed(1, 0, 0, 100, 'h00100, 'h00200);           // backward smaller
    send_directed(-5, 0, 0, 4, 'h12345, 'h54321);            // forward by one
    send_directed(-4, 0, 0, 5, 'h12345, 'h54321);            // backward by one
    send_directed(-3, -1, 1, 3, 'hABCDE, 'h00001);           // straight line
    send_directed(-32768, 32767, -32768, -32768, 'hFFFFF, 'hFFFFF);
    send_directed(32767, -32768, 32767, 32767, 'hFFFFF, 'hFFFFF);
    send_directed(0, -32768, 32767, 0, 'hFFFFF, 0);          // widest first difference
    send_directed(0, 32767, -32768, 0, 'hFFFFF, 'h000FF);
    send_directed(-1, -1, -1, -1, 'h000FF, 'hFFF00);         // fraction bits alone

    // Random part, in stretches of 64 windows, each back-to-back or gapped at random.
    burst = 1'b0;
    for (int i = 0; i < RANDOM_WINDOWS; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      send_window(pick_window(), burst ? 0 : pick_gap());
    end
    @(negedge clk);
    start = 1'b0;

    // Drain, then wait out more than a pipeline depth for stray strobes.
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0)
      $display("** eno_quadratic_interpolant: PASSED **");
    else
      $display("** eno_quadratic_interpolant: FAILED **");
    $finish;
  end

endmodule
